/* rtl/snfe_pkg.sv */
// Shared types and constants for the SMS notice field extractor.
// No dependencies; every other file imports this package.
package snfe_pkg;

	localparam int unsigned NumberDigitsDef = 10;
	localparam int unsigned TextLengthDef   = 16;

	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned NUMBER_W = 40;

	localparam logic [NUMBER_W-1:0] ALLOWED_RESET = 40'd641100444532;

	// header "+CM" and the OK tracker
	localparam logic [BYTE_W-1:0] HDR_PLUS = 8'h2B;
	localparam logic [BYTE_W-1:0] HDR_C    = 8'h43;
	localparam logic [BYTE_W-1:0] HDR_M    = 8'h4D;
	localparam logic [BYTE_W-1:0] CHR_O    = 8'h4F;
	localparam logic [BYTE_W-1:0] CHR_K    = 8'h4B;
	localparam logic [3:0]        ASCII_DIGIT_HI = 4'h3;

	// header count codes
	localparam logic [1:0] HC_PLUS = 2'd0;
	localparam logic [1:0] HC_C    = 2'd1;
	localparam logic [1:0] HC_M    = 2'd2;

	// positions counted from 0 on the 'M'
	localparam int unsigned DigitFirst = 8;
	localparam int unsigned TextFirst  = 41;

	typedef struct packed {
		logic              echo_valid;
		logic [BYTE_W-1:0] echo_byte;
		logic              message_done;
		logic              sender_authorized;
		logic              ok_seen;
	} result_t;

endpackage

/* rtl/snfe_ifs.sv */
// Channel interfaces of the SMS notice field extractor: received bytes in,
// result beats out. Depends on snfe_pkg.
interface snfe_byte_if import snfe_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

interface snfe_result_if import snfe_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              echo_valid;
	logic [BYTE_W-1:0] echo_byte;
	logic              message_done;
	logic              sender_authorized;
	logic              ok_seen;

	modport source (output valid, output echo_valid, output echo_byte,
		output message_done, output sender_authorized, output ok_seen, input ready);
	modport sink   (input valid, input echo_valid, input echo_byte,
		input message_done, input sender_authorized, input ok_seen, output ready);
endinterface

/* rtl/snfe_parser.sv */
// Header search, capture counters, sender compare and OK tracking.
// Updates its state once per stepped byte. Depends on snfe_pkg.
module snfe_parser import snfe_pkg::*; #(
	parameter int unsigned NUMBER_DIGITS = NumberDigitsDef,
	parameter int unsigned TEXT_LENGTH   = TextLengthDef
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  logic [BYTE_W-1:0]   rx_byte,
	input  logic [NUMBER_W-1:0] allowed_number,
	output result_t             res
);

	localparam int unsigned POS_W = $clog2(TextFirst + TEXT_LENGTH + 1);
	localparam int unsigned TC_W  = $clog2(TEXT_LENGTH + 1);
	localparam int unsigned IDX_W = (NUMBER_DIGITS > 1) ? $clog2(NUMBER_DIGITS) : 1;

	logic [1:0]       hcnt_q, hcnt_n;
	logic             cap_q, cap_n;
	logic [POS_W-1:0] pos_q, pos_n;
	logic [TC_W-1:0]  tc_q, tc_n;
	logic             mism_q, mism_n;
	logic             opend_q, opend_n;
	logic             ok_q, ok_n;

	logic [BYTE_W-1:0] hdr_exp;
	logic              cap_now;
	logic [POS_W-1:0]  pos_cur;
	logic              in_digits, in_text, done;
	logic [POS_W-1:0]  dig_off;
	logic [IDX_W-1:0]  dig_idx;
	logic [3:0]        nib_sel;
	logic [63:0]       number_wide, number_shr;
	logic [BYTE_W-1:0] dig_exp;

	always_comb begin
		case (hcnt_q)
			HC_PLUS: hdr_exp = HDR_PLUS;
			HC_C:    hdr_exp = HDR_C;
			default: hdr_exp = HDR_M;
		endcase
	end

	// expected ASCII digit: nibble NUMBER_DIGITS-1-idx of the number
	assign dig_off     = pos_cur - POS_W'(DigitFirst);
	assign dig_idx     = dig_off[IDX_W-1:0];
	assign nib_sel     = 4'(NUMBER_DIGITS - 1) - 4'(dig_idx);
	assign number_wide = {{(64-NUMBER_W){1'b0}}, allowed_number};
	assign number_shr  = number_wide >> {nib_sel, 2'b00};
	assign dig_exp     = {ASCII_DIGIT_HI, number_shr[3:0]};

	always_comb begin
		opend_n = opend_q;
		ok_n    = ok_q;
		if (rx_byte == CHR_O) begin
			opend_n = 1'b1;
		end else if (rx_byte == CHR_K && opend_q) begin
			ok_n    = 1'b1;
			opend_n = 1'b0;
		end

		hcnt_n  = 2'd0;
		cap_now = cap_q;
		if (!cap_q) begin
			if (rx_byte == hdr_exp) begin
				if (hcnt_q == HC_M) begin
					cap_now = 1'b1;
				end else begin
					hcnt_n = hcnt_q + 2'd1;
				end
			end
		end

		pos_cur   = cap_q ? pos_q : '0;
		in_digits = cap_now && pos_cur >= POS_W'(DigitFirst)
			&& pos_cur < POS_W'(DigitFirst + NUMBER_DIGITS);
		in_text   = cap_now && pos_cur >= POS_W'(TextFirst)
			&& pos_cur < POS_W'(TextFirst + TEXT_LENGTH);

		mism_n = mism_q | (in_digits && rx_byte != dig_exp);
		tc_n   = tc_q + TC_W'(in_text);
		pos_n  = cap_now ? pos_cur + POS_W'(1) : pos_q;
		cap_n  = cap_now;
		done   = cap_now && tc_n == TC_W'(TEXT_LENGTH);

		res.echo_valid        = in_text;
		res.echo_byte         = in_text ? rx_byte : '0;
		res.message_done      = done;
		res.sender_authorized = done && !mism_n;
		res.ok_seen           = ok_n;

		// drop back to header search after the last text byte
		if (done) begin
			cap_n  = 1'b0;
			pos_n  = '0;
			tc_n   = '0;
			mism_n = 1'b0;
			hcnt_n = 2'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hcnt_q  <= 2'd0;
			cap_q   <= 1'b0;
			pos_q   <= '0;
			tc_q    <= '0;
			mism_q  <= 1'b0;
			opend_q <= 1'b0;
			ok_q    <= 1'b0;
		end else if (step) begin
			hcnt_q  <= hcnt_n;
			cap_q   <= cap_n;
			pos_q   <= pos_n;
			tc_q    <= tc_n;
			mism_q  <= mism_n;
			opend_q <= opend_n;
			ok_q    <= ok_n;
		end
	end

endmodule

/* rtl/sms_notice_field_extractor_top.sv */
// SMS notice field extractor: usage
// Channels: in_ch carries one received modem byte per beat (rx_byte); out_ch
// returns exactly one result beat per input beat, in order: echo_valid and
// echo_byte for message text, message_done with sender_authorized on the
// last text byte, and the sticky ok_seen flag.
// Configuration: cfg_wr_en/cfg_wr_data write the ten-digit BCD sender number
// (most significant digit first); write it only while no beat is in flight.
// Pipeline: an accepted byte is held in the input register, and its result
// beat in the result register, from which out_ch takes it.
// Throughput: one byte per cycle while out_ch.ready is high; the header,
// counter and digit compare logic all sits between those two registers.
// Reset: arst_n clears header search, capture counters, the OK flag and the valid
// flags of both register stages, and loads the default sender number.
// Stall: while out_ch.ready is low the result is held; at most one more byte is taken
// into the input register, after which in_ch.ready drops until the result moves.
// Depends on snfe_pkg, snfe_ifs and snfe_parser.
module sms_notice_field_extractor_top import snfe_pkg::*; #(
	parameter int unsigned NUMBER_DIGITS = NumberDigitsDef,
	parameter int unsigned TEXT_LENGTH   = TextLengthDef
) (
	input  logic                clk,
	input  logic                arst_n,
	snfe_byte_if.sink           in_ch,
	snfe_result_if.source       out_ch,
	input  logic                cfg_wr_en,
	input  logic [NUMBER_W-1:0] cfg_wr_data
);

	logic [NUMBER_W-1:0] number_q;
	logic                valid_s1;
	logic [BYTE_W-1:0]   byte_s1;
	logic                valid_s2;
	result_t             res_s2;
	result_t             res;
	logic                adv;
	logic                in_fire;

	assign adv          = valid_s1 && (!valid_s2 || out_ch.ready);
	assign in_ch.ready  = !valid_s1 || !valid_s2 || out_ch.ready;
	assign in_fire      = in_ch.valid && in_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			number_q <= ALLOWED_RESET;
		end else if (cfg_wr_en) begin
			number_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= in_fire || (valid_s1 && !adv);
			valid_s2 <= adv || (valid_s2 && !out_ch.ready);
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			byte_s1 <= in_ch.rx_byte;
		end
		if (adv) begin
			res_s2 <= res;
		end
	end

	snfe_parser #(
		.NUMBER_DIGITS(NUMBER_DIGITS),
		.TEXT_LENGTH  (TEXT_LENGTH)
	) u_parser (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (adv),
		.rx_byte       (byte_s1),
		.allowed_number(number_q),
		.res           (res)
	);

	assign out_ch.valid             = valid_s2;
	assign out_ch.echo_valid        = res_s2.echo_valid;
	assign out_ch.echo_byte         = res_s2.echo_byte;
	assign out_ch.message_done      = res_s2.message_done;
	assign out_ch.sender_authorized = res_s2.sender_authorized;
	assign out_ch.ok_seen           = res_s2.ok_seen;

`ifndef ASSERT_OFF
	a_done_on_text: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && res_s2.message_done |-> res_s2.echo_valid)
		else $error("message_done on a beat that is not text");

	a_auth_with_done: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && res_s2.sender_authorized |-> res_s2.message_done)
		else $error("sender_authorized without message_done");

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ch.ready |-> valid_s1 && valid_s2 && !adv)
		else $error("input stalled while a stage is free");
`endif

endmodule
